>>> hw/rtl/btt_pkg.sv
package btt_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_STORED     = 2'd0,
        STATUS_LIMIT_ZERO = 2'd1,
        STATUS_KEY_FULL   = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_INSERT,
        ST_DONE
    } state_t;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_KEYS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_EVENTS = 4'd1;

    localparam logic [4:0] MAX_KEYS_RESET   = 5'd16;
    localparam logic [7:0] MAX_EVENTS_RESET = 8'd255;

    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [4:0] max_keys;
        logic [7:0] max_events;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  slot;
        logic [7:0]  event_index;
        logic        new_key;
        logic        evicted;
        logic [4:0]  key_count;
        logic [7:0]  key_events;
        logic [31:0] evicted_total;
        logic [31:0] dropped_total;
    } res_t;

endpackage

>>> hw/rtl/bounded_trace_table_fifo_evict_unit.sv
// Trace event table with FIFO key replacement.
//
// Requests arrive on the s_ channel (valid/ready), one 64-bit trace key each.
// Each request gives exactly one result on the m_ channel: status, slot, event
// index, new/evicted flags, key and event counts, and the saturating totals.
// Limits are written on the cfg_ channel (index 0 max_keys, index 1
// max_events); cfg_ready is always high and a write takes effect at once.
//
// A request with a zero limit goes from the idle state straight to the done
// state. Otherwise the stored keys are read one per cycle from the key memory
// and compared until a key matches or all occupied slots have been read. One
// request is worked on at a time; s_ready is high once the previous result has
// been handed to the output register, so no new request is taken before then.
// The output register holds a result while m_ready is low; the next request
// is still accepted and its result waits inside until the register frees.
// Reset clears occupancy, the oldest pointer and both totals, and sets the
// limits to 16 and 255. The memories need no clearing.
module bounded_trace_table_fifo_evict_unit #(
    parameter int KEY_SLOTS   = 16,
    parameter int EVENT_LIMIT = 255,
    parameter int KEY_BITS    = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [63:0]                       s_trace_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [3:0]                        m_slot,
    output logic [7:0]                        m_event_index,
    output logic                              m_new_key,
    output logic                              m_evicted,
    output logic [4:0]                        m_key_count,
    output logic [7:0]                        m_key_events,
    output logic [31:0]                       m_evicted_total,
    output logic [31:0]                       m_dropped_total,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [btt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [btt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    btt_pkg::cfg_t cfg_reg, cfg_next;
    btt_pkg::res_t out_reg;
    logic          m_valid_reg;

    btt_pkg::res_t       res;
    logic                res_valid;
    logic                res_ready;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic [KEY_BITS-1:0] rd_key;
    logic [7:0]          rd_cnt;
    logic [SLOT_W-1:0]   wr_addr;
    logic                wr_key_en;
    logic [KEY_BITS-1:0] wr_key;
    logic                wr_cnt_en;
    logic [7:0]          wr_cnt;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                btt_pkg::CFG_IDX_MAX_KEYS:   cfg_next.max_keys   = cfg_data[4:0];
                btt_pkg::CFG_IDX_MAX_EVENTS: cfg_next.max_events = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_keys   <= btt_pkg::MAX_KEYS_RESET;
            cfg_reg.max_events <= btt_pkg::MAX_EVENTS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_slot          = out_reg.slot;
    assign m_event_index   = out_reg.event_index;
    assign m_new_key       = out_reg.new_key;
    assign m_evicted       = out_reg.evicted;
    assign m_key_count     = out_reg.key_count;
    assign m_key_events    = out_reg.key_events;
    assign m_evicted_total = out_reg.evicted_total;
    assign m_dropped_total = out_reg.dropped_total;

    btt_seq #(
        .KEY_SLOTS   (KEY_SLOTS),
        .EVENT_LIMIT (EVENT_LIMIT),
        .KEY_BITS    (KEY_BITS),
        .SLOT_W      (SLOT_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_key    (s_trace_key[KEY_BITS-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_cnt    (rd_cnt),
        .wr_addr   (wr_addr),
        .wr_key_en (wr_key_en),
        .wr_key    (wr_key),
        .wr_cnt_en (wr_cnt_en),
        .wr_cnt    (wr_cnt)
    );

    btt_table_mem #(
        .KEY_SLOTS (KEY_SLOTS),
        .KEY_BITS  (KEY_BITS),
        .SLOT_W    (SLOT_W)
    ) u_table_mem (
        .aclk      (aclk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_cnt    (rd_cnt),
        .wr_addr   (wr_addr),
        .wr_key_en (wr_key_en),
        .wr_key    (wr_key),
        .wr_cnt_en (wr_cnt_en),
        .wr_cnt    (wr_cnt)
    );

endmodule

>>> hw/rtl/btt_table_mem.sv
module btt_table_mem #(
    parameter int KEY_SLOTS = 16,
    parameter int KEY_BITS  = 64,
    parameter int SLOT_W    = 4
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [SLOT_W-1:0]   rd_addr,
    output logic [KEY_BITS-1:0] rd_key,
    output logic [7:0]          rd_cnt,
    input  logic [SLOT_W-1:0]   wr_addr,
    input  logic                wr_key_en,
    input  logic [KEY_BITS-1:0] wr_key,
    input  logic                wr_cnt_en,
    input  logic [7:0]          wr_cnt
);

    logic [KEY_BITS-1:0] key_mem [KEY_SLOTS];
    logic [7:0]          cnt_mem [KEY_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_cnt_en) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key <= key_mem[rd_addr];
            rd_cnt <= cnt_mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/btt_seq.sv
module btt_seq #(
    parameter int KEY_SLOTS   = 16,
    parameter int EVENT_LIMIT = 255,
    parameter int KEY_BITS    = 64,
    parameter int SLOT_W      = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  btt_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KEY_BITS-1:0] in_key,
    output logic                res_valid,
    input  logic                res_ready,
    output btt_pkg::res_t       res,
    output logic                rd_en,
    output logic [SLOT_W-1:0]   rd_addr,
    input  logic [KEY_BITS-1:0] rd_key,
    input  logic [7:0]          rd_cnt,
    output logic [SLOT_W-1:0]   wr_addr,
    output logic                wr_key_en,
    output logic [KEY_BITS-1:0] wr_key,
    output logic                wr_cnt_en,
    output logic [7:0]          wr_cnt
);

    localparam int OCC_W = $clog2(KEY_SLOTS + 1);
    localparam int SUM_W = OCC_W + 1;

    btt_pkg::state_t state_reg, state_next;

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]   oldest_reg, oldest_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [OCC_W-1:0]    issue_reg, issue_next;
    logic [SLOT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic                pend_reg, pend_next;
    logic [SLOT_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic [31:0]         evict_total_reg, evict_total_next;
    logic [31:0]         drop_total_reg, drop_total_next;
    btt_pkg::res_t       res_reg, res_next;

    logic [OCC_W-1:0]  key_lim;
    logic [7:0]        ev_lim;
    logic              limit_zero;
    logic              match;
    logic              scan_done;
    logic              evict_now;
    logic [SUM_W-1:0]  tail_sum;
    logic [SLOT_W-1:0] tail;
    logic [SLOT_W-1:0] oldest_inc;
    logic [SLOT_W-1:0] rd_ptr_inc;

    assign key_lim = (32'(cfg.max_keys) < KEY_SLOTS) ? OCC_W'(cfg.max_keys)
                                                     : OCC_W'(KEY_SLOTS);
    assign ev_lim  = (32'(cfg.max_events) < EVENT_LIMIT) ? cfg.max_events
                                                         : 8'(EVENT_LIMIT);
    assign limit_zero = (key_lim == '0) || (ev_lim == '0);

    // The compare sees the entry that was addressed in the previous cycle.
    assign match     = pend_reg && (rd_key == key_reg);
    assign scan_done = (issue_reg == occ_reg);
    assign evict_now = (occ_reg >= key_lim);

    // The free slot sits right behind the newest key of the ring.
    assign tail_sum = SUM_W'(oldest_reg) + SUM_W'(occ_reg);
    assign tail     = (tail_sum >= SUM_W'(KEY_SLOTS)) ? SLOT_W'(tail_sum - SUM_W'(KEY_SLOTS))
                                                      : SLOT_W'(tail_sum);

    assign oldest_inc = (oldest_reg == SLOT_W'(KEY_SLOTS - 1)) ? '0 : oldest_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == SLOT_W'(KEY_SLOTS - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            btt_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (limit_zero) begin
                        state_next = btt_pkg::ST_DONE;
                    end else if (occ_reg == '0) begin
                        state_next = btt_pkg::ST_INSERT;
                    end else begin
                        state_next = btt_pkg::ST_SCAN;
                    end
                end
            end
            btt_pkg::ST_SCAN: begin
                if (match) begin
                    state_next = btt_pkg::ST_HIT;
                end else if (scan_done) begin
                    state_next = btt_pkg::ST_INSERT;
                end
            end
            btt_pkg::ST_HIT:    state_next = btt_pkg::ST_DONE;
            btt_pkg::ST_INSERT: state_next = btt_pkg::ST_DONE;
            btt_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = btt_pkg::ST_IDLE;
                end
            end
            default: state_next = btt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        key_next         = key_reg;
        oldest_next      = oldest_reg;
        occ_next         = occ_reg;
        issue_next       = issue_reg;
        rd_ptr_next      = rd_ptr_reg;
        pend_next        = 1'b0;
        pend_addr_next   = pend_addr_reg;
        slot_next        = slot_reg;
        cnt_next         = cnt_reg;
        evict_total_next = evict_total_reg;
        drop_total_next  = drop_total_reg;
        res_next         = res_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = rd_ptr_reg;
        wr_addr          = slot_reg;
        wr_key_en        = 1'b0;
        wr_key           = key_reg;
        wr_cnt_en        = 1'b0;
        wr_cnt           = 8'd1;

        unique case (state_reg)
            btt_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    key_next    = in_key;
                    issue_next  = '0;
                    rd_ptr_next = oldest_reg;
                    if (limit_zero) begin
                        if (drop_total_reg != btt_pkg::TOTAL_MAX) begin
                            drop_total_next = drop_total_reg + 32'd1;
                        end
                        res_next             = '0;
                        res_next.status      = btt_pkg::STATUS_LIMIT_ZERO;
                        res_next.key_count   = 5'(occ_reg);
                    end
                end
            end
            btt_pkg::ST_SCAN: begin
                if (match) begin
                    slot_next = pend_addr_reg;
                    cnt_next  = rd_cnt;
                end else if (!scan_done) begin
                    rd_en          = 1'b1;
                    rd_ptr_next    = rd_ptr_inc;
                    issue_next     = issue_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                end
            end
            btt_pkg::ST_HIT: begin
                res_next           = '0;
                res_next.slot      = 4'(slot_reg);
                res_next.key_count = 5'(occ_reg);
                if (cnt_reg >= ev_lim) begin
                    if (drop_total_reg != btt_pkg::TOTAL_MAX) begin
                        drop_total_next = drop_total_reg + 32'd1;
                    end
                    res_next.status     = btt_pkg::STATUS_KEY_FULL;
                    res_next.key_events = cnt_reg;
                end else begin
                    wr_cnt_en            = 1'b1;
                    wr_cnt               = cnt_reg + 8'd1;
                    res_next.status      = btt_pkg::STATUS_STORED;
                    res_next.event_index = cnt_reg;
                    res_next.key_events  = cnt_reg + 8'd1;
                end
            end
            btt_pkg::ST_INSERT: begin
                wr_addr             = tail;
                wr_key_en           = 1'b1;
                wr_cnt_en           = 1'b1;
                wr_cnt              = 8'd1;
                res_next            = '0;
                res_next.status     = btt_pkg::STATUS_STORED;
                res_next.slot       = 4'(tail);
                res_next.new_key    = 1'b1;
                res_next.evicted    = evict_now;
                res_next.key_events = 8'd1;
                // With the table at its limit the oldest key gives up its slot,
                // so the number of keys stays the same.
                if (evict_now) begin
                    oldest_next = oldest_inc;
                    if (evict_total_reg != btt_pkg::TOTAL_MAX) begin
                        evict_total_next = evict_total_reg + 32'd1;
                    end
                    res_next.key_count = 5'(occ_reg);
                end else begin
                    occ_next           = occ_reg + 1'b1;
                    res_next.key_count = 5'(occ_reg + 1'b1);
                end
            end
            btt_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res               = res_reg;
        res.evicted_total = evict_total_reg;
        res.dropped_total = drop_total_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= btt_pkg::ST_IDLE;
            oldest_reg      <= '0;
            occ_reg         <= '0;
            pend_reg        <= 1'b0;
            evict_total_reg <= '0;
            drop_total_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            oldest_reg      <= oldest_next;
            occ_reg         <= occ_next;
            pend_reg        <= pend_next;
            evict_total_reg <= evict_total_next;
            drop_total_reg  <= drop_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        issue_reg     <= issue_next;
        rd_ptr_reg    <= rd_ptr_next;
        pend_addr_reg <= pend_addr_next;
        slot_reg      <= slot_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
    end

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(KEY_SLOTS))
        else $error("occupancy above table size");

    a_key_write_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_key_en |-> (state_reg == btt_pkg::ST_INSERT) && !rd_en)
        else $error("key write outside insert");

    a_drop_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> drop_total_reg >= $past(drop_total_reg))
        else $error("dropped total went down");

    a_stored_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == btt_pkg::ST_DONE) && (res_reg.status == btt_pkg::STATUS_STORED)
        |-> res_reg.key_events == 8'(res_reg.event_index + 8'd1))
        else $error("stored result count does not follow its index");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int KEY_SLOTS   = 16;
    localparam int EVENT_LIMIT = 255;
    localparam int IDLE_LIMIT  = 2000;

    class trace_table_predictor;
        logic [63:0]    key_store[KEY_SLOTS];
        bit             slot_used[KEY_SLOTS];
        int unsigned    slot_events[KEY_SLOTS];
        int unsigned    oldest;
        int unsigned    occupancy;
        logic [31:0]    evict_total;
        logic [31:0]    drop_total;
        logic [4:0]     max_keys;
        logic [7:0]     max_events;
        btt_pkg::res_t  expected_results[$];
        int             errors;

        function new();
            for (int i = 0; i < KEY_SLOTS; i++) begin
                key_store[i]   = '0;
                slot_used[i]   = 1'b0;
                slot_events[i] = 0;
            end
            oldest      = 0;
            occupancy   = 0;
            evict_total = '0;
            drop_total  = '0;
            max_keys    = btt_pkg::MAX_KEYS_RESET;
            max_events  = btt_pkg::MAX_EVENTS_RESET;
            errors      = 0;
        endfunction

        function void write_reg(logic [btt_pkg::CFG_IDX_W-1:0] idx,
                                logic [btt_pkg::CFG_DATA_W-1:0] data);
            if (idx == btt_pkg::CFG_IDX_MAX_KEYS) begin
                max_keys = data[4:0];
            end else if (idx == btt_pkg::CFG_IDX_MAX_EVENTS) begin
                max_events = data;
            end
        endfunction

        function void note_event(logic [63:0] key);
            int unsigned   key_lim;
            int unsigned   ev_lim;
            int unsigned   s;
            bit            found;
            btt_pkg::res_t r;
            key_lim = (max_keys < KEY_SLOTS) ? max_keys : KEY_SLOTS;
            ev_lim  = (max_events < EVENT_LIMIT) ? max_events : EVENT_LIMIT;
            r = '0;
            if (key_lim == 0 || ev_lim == 0) begin
                if (drop_total != btt_pkg::TOTAL_MAX) drop_total++;
                r.status = btt_pkg::STATUS_LIMIT_ZERO;
            end else begin
                found = 1'b0;
                s = 0;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (!found && slot_used[i] && key_store[i] == key) begin
                        s = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    // A full table gives up its oldest key before the insert.
                    if (occupancy >= key_lim && occupancy > 0) begin
                        slot_used[oldest]   = 1'b0;
                        slot_events[oldest] = 0;
                        oldest = (oldest + 1) % KEY_SLOTS;
                        occupancy--;
                        if (evict_total != btt_pkg::TOTAL_MAX) evict_total++;
                        r.evicted = 1'b1;
                    end
                    s = (oldest + occupancy) % KEY_SLOTS;
                    key_store[s]   = key;
                    slot_used[s]   = 1'b1;
                    slot_events[s] = 0;
                    occupancy++;
                    r.new_key = 1'b1;
                end
                if (slot_events[s] >= ev_lim) begin
                    if (drop_total != btt_pkg::TOTAL_MAX) drop_total++;
                    r.status = btt_pkg::STATUS_KEY_FULL;
                end else begin
                    r.status      = btt_pkg::STATUS_STORED;
                    r.event_index = 8'(slot_events[s]);
                    slot_events[s]++;
                end
                r.slot       = 4'(s);
                r.key_events = 8'(slot_events[s]);
            end
            r.key_count     = 5'(occupancy);
            r.evicted_total = evict_total;
            r.dropped_total = drop_total;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(btt_pkg::res_t got);
            btt_pkg::res_t exp_r;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending, expected none, actual status %0d",
                         $time, got.status);
                errors++;
                return;
            end
            exp_r = expected_results[0];
            expected_results.delete(0);
            cmp_field("status", exp_r.status, got.status);
            cmp_field("slot", exp_r.slot, got.slot);
            cmp_field("event_index", exp_r.event_index, got.event_index);
            cmp_field("new_key", exp_r.new_key, got.new_key);
            cmp_field("evicted", exp_r.evicted, got.evicted);
            cmp_field("key_count", exp_r.key_count, got.key_count);
            cmp_field("key_events", exp_r.key_events, got.key_events);
            cmp_field("evicted_total", exp_r.evicted_total, got.evicted_total);
            cmp_field("dropped_total", exp_r.dropped_total, got.dropped_total);
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [63:0]                    s_trace_key = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [1:0]                     m_status;
    logic [3:0]                     m_slot;
    logic [7:0]                     m_event_index;
    logic                           m_new_key;
    logic                           m_evicted;
    logic [4:0]                     m_key_count;
    logic [7:0]                     m_key_events;
    logic [31:0]                    m_evicted_total;
    logic [31:0]                    m_dropped_total;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [btt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [btt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    trace_table_predictor sb = new();

    logic [63:0] key_pool[24];
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int          rx_hold_cycles = 0;
    int          idle_count = 0;

    bounded_trace_table_fifo_evict_unit i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Ends the run if no channel moves anything for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_key(input logic [63:0] key);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_trace_key <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_event(key);
    endtask

    task automatic write_reg(input logic [btt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [btt_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic drain();
        wait_results();
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_key(int hot_pct, int pool_n, int rnd_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < hot_pct) return key_pool[0];
        if (r < 100 - rnd_pct) return key_pool[$urandom_range(1, pool_n - 1)];
        return {$urandom, $urandom};
    endfunction

    initial begin : result_sink
        int            gap;
        btt_pkg::res_t got;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.status        = btt_pkg::status_t'(m_status);
            got.slot          = m_slot;
            got.event_index   = m_event_index;
            got.new_key       = m_new_key;
            got.evicted       = m_evicted;
            got.key_count     = m_key_count;
            got.key_events    = m_key_events;
            got.evicted_total = m_evicted_total;
            got.dropped_total = m_dropped_total;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        logic [btt_pkg::CFG_DATA_W-1:0] mk;
        logic [btt_pkg::CFG_DATA_W-1:0] me;
        logic [btt_pkg::CFG_IDX_W-1:0]  bad_idx;
        int n_items;
        int hot;
        int pool_n;
        int rnd;
        for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the table, then push two new keys so the two oldest go in order.
        send_key(64'h0);
        send_key('1);
        send_key(64'h0);
        for (int k = 1; k < 15; k++) send_key(64'h8000_0000_0000_0000 | 64'(k));
        send_key(64'h8000_0000_0000_000F);
        send_key(64'h0);
        drain();

        // Zero key limit drops everything and leaves the table alone.
        write_reg(btt_pkg::CFG_IDX_MAX_KEYS, 8'h00);
        send_key('1);
        send_key(64'h0);
        drain();

        // A key limit above the table size, with a zero event limit.
        write_reg(btt_pkg::CFG_IDX_MAX_KEYS, 8'hFF);
        write_reg(btt_pkg::CFG_IDX_MAX_EVENTS, 8'h00);
        send_key(64'h0);
        drain();

        // Lowered event limit: a new key stores two events, then its third drops.
        write_reg(btt_pkg::CFG_IDX_MAX_EVENTS, 8'h02);
        send_key(64'h0);
        send_key(64'h5555_AAAA_5555_AAAA);
        send_key(64'h5555_AAAA_5555_AAAA);
        send_key(64'h5555_AAAA_5555_AAAA);
        drain();

        // Key limit of one on a full table: each new key evicts one old key.
        write_reg(btt_pkg::CFG_IDX_MAX_KEYS, 8'h01);
        send_key(64'h1234_5678_9ABC_DEF0);
        send_key(64'hFEDC_BA98_7654_3210);
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            n_items = 15;
            hot     = 0;
            pool_n  = 24;
            rnd     = 10;
            case (phase)
                0: begin mk = 8'd16; me = 8'd255; end
                1: begin mk = 8'd4; me = 8'd3; pool_n = 8; end
                2: begin mk = 8'd16; me = 8'd255; end
                3: begin mk = 8'($urandom_range(0, 7)) << 5; me = 8'($urandom); n_items = 10; end
                4: begin mk = 8'($urandom_range(17, 31)) | 8'($urandom_range(0, 7) << 5);
                         me = 8'd1; pool_n = 20; rnd = 20; end
                5: begin mk = 8'd1; me = 8'd255; hot = 30; pool_n = 4; end
                6: begin mk = 8'($urandom); me = 8'($urandom_range(1, 8)); end
                7: begin mk = 8'($urandom); me = 8'($urandom); end
                8: begin mk = 8'd16; me = 8'd255; n_items = 270; hot = 97; pool_n = 11;
                         rnd = 0; end
                default: begin mk = 8'($urandom_range(2, 15)); me = 8'd0; n_items = 10; end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(btt_pkg::CFG_IDX_MAX_KEYS, mk);
                write_reg(btt_pkg::CFG_IDX_MAX_EVENTS, me);
            end else begin
                write_reg(btt_pkg::CFG_IDX_MAX_EVENTS, me);
                write_reg(btt_pkg::CFG_IDX_MAX_KEYS, mk);
            end
            bad_idx = btt_pkg::CFG_IDX_W'($urandom_range(btt_pkg::CFG_IDX_MAX_EVENTS + 1,
                                                         (1 << btt_pkg::CFG_IDX_W) - 1));
            write_reg(bad_idx, 8'($urandom));

            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            // Stall the result side long enough to back requests up into the block.
            if (phase == 2) rx_hold_cycles = 120;

            for (int i = 0; i < n_items; i++) begin
                if (phase == 5 && i == n_items / 2) wait_results();
                send_key(pick_key(hot, pool_n, rnd));
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
